FILE: hw/rtl/lrsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG string generator package
// Generator constants, the head-of-queue type and the character mapping.
// ----------------------------------------------------------------------------
package lrsg_pkg;

  localparam int unsigned SEED_W  = 32;
  localparam int unsigned STATE_W = 31;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned IDX_W   = 6;

  localparam logic [STATE_W-1:0] LCG_MUL = STATE_W'(214013);
  localparam logic [STATE_W-1:0] LCG_ADD = STATE_W'(2531011);

  // Alphabet orderings selected by the configuration register.
  localparam logic [SEL_W-1:0] ALPHA_DIG_UP_LO = 2'd0;
  localparam logic [SEL_W-1:0] ALPHA_DIG_LO_UP = 2'd1;
  localparam logic [SEL_W-1:0] ALPHA_UP_LO_DIG = 2'd2;
  localparam logic [SEL_W-1:0] ALPHA_LO_UP_DIG = 2'd3;
  localparam logic [SEL_W-1:0] ALPHA_RESET     = ALPHA_DIG_LO_UP;

  localparam logic [CHAR_W-1:0] ASCII_DIGIT = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 7'h61;

  typedef struct packed {
    logic              valid;
    logic [SEED_W-1:0] seed;
  } seed_head_t;

  // Remainder by 62 of a 15-bit value: split off the low bit and reduce the
  // rest modulo 31 by folding 5-bit digits, since 32 is 1 modulo 31.
  function automatic logic [IDX_W-1:0] mod62(input logic [14:0] x);
    logic [13:0] h;
    logic [6:0]  s1;
    logic [5:0]  s2;
    logic [4:0]  r;
    h  = x[14:1];
    s1 = 7'(h[4:0]) + 7'(h[9:5]) + 7'(h[13:10]);
    s2 = 6'(s1[4:0]) + 6'(s1[6:5]);
    r  = (s2 >= 6'd31) ? 5'(s2 - 6'd31) : s2[4:0];
    return {r, x[0]};
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [SEL_W-1:0] sel,
                                                   input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] i;
    logic [CHAR_W-1:0] c;
    i = CHAR_W'(idx);
    case (sel)
      ALPHA_DIG_UP_LO: begin
        if (i < 7'd10) c = ASCII_DIGIT + i;
        else if (i < 7'd36) c = ASCII_UPPER + i - 7'd10;
        else c = ASCII_LOWER + i - 7'd36;
      end
      ALPHA_DIG_LO_UP: begin
        if (i < 7'd10) c = ASCII_DIGIT + i;
        else if (i < 7'd36) c = ASCII_LOWER + i - 7'd10;
        else c = ASCII_UPPER + i - 7'd36;
      end
      ALPHA_UP_LO_DIG: begin
        if (i < 7'd26) c = ASCII_UPPER + i;
        else if (i < 7'd52) c = ASCII_LOWER + i - 7'd26;
        else c = ASCII_DIGIT + i - 7'd52;
      end
      default: begin
        if (i < 7'd26) c = ASCII_LOWER + i;
        else if (i < 7'd52) c = ASCII_UPPER + i - 7'd26;
        else c = ASCII_DIGIT + i - 7'd52;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lrsg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG string generator seed queue
// Accepts seed requests into a two-entry queue that feeds the generator.
// ----------------------------------------------------------------------------
module lrsg_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       seed_valid,
  output logic                            seed_ready,
  input  wire logic [lrsg_pkg::SEED_W-1:0] seed,
  output lrsg_pkg::seed_head_t            head,
  input  wire logic                       pop
);

  logic [lrsg_pkg::SEED_W-1:0] slots [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  fill;
  logic                        push;
  logic                        take;

  assign seed_ready = (fill != 2'd2);
  assign push       = seed_valid && seed_ready;
  assign take       = pop && (fill != 2'd0);

  assign head.valid = (fill != 2'd0);
  assign head.seed  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      if (push && !take) fill <= fill + 2'd1;
      else if (take && !push) fill <= fill - 2'd1;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lrsg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG string generator core
// Steps the generator once per character and holds each character in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module lrsg_back #(
  parameter int unsigned STRING_LENGTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lrsg_pkg::seed_head_t        head,
  output logic                             pop,
  input  wire logic [lrsg_pkg::SEL_W-1:0]  alphabet_select,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lrsg_pkg::CHAR_W-1:0]      character,
  output logic [lrsg_pkg::POS_W-1:0]       position,
  output logic                             last
);

  localparam int unsigned CNT_W = (STRING_LENGTH > 1) ? $clog2(STRING_LENGTH) : 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(STRING_LENGTH - 1);

  logic                                busy;
  logic [CNT_W-1:0]                    count;
  logic [lrsg_pkg::STATE_W-1:0]        state;
  logic [lrsg_pkg::STATE_W-1:0]        src;
  logic [lrsg_pkg::STATE_W-1:0]        state_next;
  logic [lrsg_pkg::IDX_W-1:0]          pick;
  logic [CNT_W+lrsg_pkg::POS_W-1:0]    count_ext;
  logic                                advance;
  logic                                at_last;

  // A new seed enters the multiplier directly, so its first character is
  // produced in the same cycle the seed leaves the queue.
  assign src        = busy ? state : head.seed[lrsg_pkg::STATE_W-1:0];
  assign state_next = src * lrsg_pkg::LCG_MUL + lrsg_pkg::LCG_ADD;
  assign pick       = lrsg_pkg::mod62(state_next[30:16]);
  assign count_ext  = {{lrsg_pkg::POS_W{1'b0}}, count};
  assign at_last    = (count == LAST_IDX);
  assign advance    = (busy || head.valid) && (!out_valid || out_ready);
  assign pop        = advance && !busy;

  always_ff @(posedge clk) begin
    if (advance) begin
      state     <= state_next;
      character <= lrsg_pkg::alpha_char(alphabet_select, pick);
      position  <= count_ext[lrsg_pkg::POS_W-1:0];
      last      <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        busy      <= !at_last;
        count     <= at_last ? '0 : count + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lcg_random_string_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG random string generator
// Turns each seed into a string of alphanumeric characters.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// seed      in         seed_valid/seed_ready  seed[31:0]
// out       out        out_valid/out_ready    character[6:0], position[3:0], last
// cfg       in         cfg_wr_en              cfg_wr_data[1:0] (alphabet select)
//
// Each seed yields STRING_LENGTH characters (16 by default), one per cycle
// while the output is not stalled. Seeds follow each other without a gap. A
// two-entry seed queue keeps the input accepting while a string is being
// generated, and the output register holds a character through any stall.
// Synchronous reset clears all control state and sets the alphabet select to 1.
// ----------------------------------------------------------------------------
module lcg_random_string_generator_unit #(
  parameter int unsigned STRING_LENGTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        seed_valid,
  output logic                             seed_ready,
  input  wire logic [lrsg_pkg::SEED_W-1:0] seed,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lrsg_pkg::CHAR_W-1:0]      character,
  output logic [lrsg_pkg::POS_W-1:0]       position,
  output logic                             last,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lrsg_pkg::SEL_W-1:0]  cfg_wr_data
);

  logic [lrsg_pkg::SEL_W-1:0] alphabet_select;
  lrsg_pkg::seed_head_t       head;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_select <= lrsg_pkg::ALPHA_RESET;
    end else if (cfg_wr_en) begin
      alphabet_select <= cfg_wr_data;
    end
  end

  lrsg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .seed       (seed),
    .head       (head),
    .pop        (pop)
  );

  lrsg_back #(
    .STRING_LENGTH (STRING_LENGTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .alphabet_select (alphabet_select),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .character       (character),
    .position        (position),
    .last            (last)
  );

endmodule
`default_nettype wire
